// ===== hdl/eca_pkg.sv =====
// shared types, codes and constants of the easing curve animator
package eca_pkg;

  // item action codes
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // curve mode codes
  localparam logic [2:0] MODE_LINEAR = 3'd0;
  localparam logic [2:0] MODE_QUAD   = 3'd1;
  localparam logic [2:0] MODE_CUBIC  = 3'd2;
  localparam logic [2:0] MODE_EXP    = 3'd3;
  localparam logic [2:0] MODE_BEZIER = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] REG_ANIMATE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_LEN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_X1        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_Y1        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_X2        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_Y2        = 3'd6;

  // register reset values
  localparam logic [15:0]        DURATION_RST = 16'd250;
  localparam logic [16:0]        CTRL_X1_RST  = 17'd16384;
  localparam logic signed [17:0] CTRL_Y1_RST  = 18'sd0;
  localparam logic [16:0]        CTRL_X2_RST  = 17'd49152;
  localparam logic signed [17:0] CTRL_Y2_RST  = 18'sd65536;

  // default bisection step count for the bezier solver
  localparam int unsigned BISECT_STEPS_DEF = 31;

  // shared multiplier operand width
  localparam int unsigned MUL_W = 34;

  // saturation limits
  localparam logic signed [52:0] SAT_MAX = 53'sd2147483647;
  localparam logic signed [52:0] SAT_MIN = -53'sd2147483648;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SHAPE,
    S_LERP,
    S_DONE
  } state_t;

  typedef logic [31:0] exp_tab_t [16];

  // floor integer square root, used only to build the constant table
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // q1.31 roots 2^(-2^-j) for j = 1..16
  function automatic exp_tab_t exp_table();
    exp_tab_t    tab;
    logic [63:0] c;
    c = 64'h1 << 30;
    for (int j = 0; j < 16; j++) begin
      c = isqrt64(c << 31);
      tab[j] = c[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_C = exp_table();

endpackage

// ===== hdl/eca_if.sv =====
// valid/ready channel interfaces for input and result items
interface eca_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] now_ms;
  logic signed [31:0] from_value;
  logic signed [31:0] to_value;
  modport source (output valid, action, now_ms, from_value, to_value, input ready);
  modport sink (input valid, action, now_ms, from_value, to_value, output ready);
endinterface

interface eca_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] current_value;
  logic        still_active;
  modport source (output valid, current_value, still_active, input ready);
  modport sink (input valid, current_value, still_active, output ready);
endinterface

// ===== hdl/easing_curve_animator_top.sv =====
// top level: registers, item handshake, curve sequencer and result stage
// A start item, or a sample taken while inactive, at or before the start time or at
// or past the duration, goes straight to the result state. A sample inside the
// animation goes through the divider for the q0.16 fraction (16 quotient bits), then
// the curve on the shared 34x34 multiplier (linear, quad-out, cubic-out, exponential,
// or bezier with BISECT_STEPS bisection steps and a final evaluation), then
// interpolation and saturation, then the result register. Input is taken only while
// the sequencer is idle, and the result register lets the next item in while a
// result waits. No memories.
module easing_curve_animator_top #(
  parameter int unsigned BISECT_STEPS = eca_pkg::BISECT_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  eca_in_if.sink                           in_ch,
  eca_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [eca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eca_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned CW = ($clog2(BISECT_STEPS) > 4) ? $clog2(BISECT_STEPS) : 4;
  localparam int unsigned MW = eca_pkg::MUL_W;

  // configuration registers
  logic               animate_enable;
  logic [2:0]         curve_mode;
  logic [15:0]        anim_len;
  logic [16:0]        ctrl_x1;
  logic signed [17:0] ctrl_y1;
  logic [16:0]        ctrl_x2;
  logic signed [17:0] ctrl_y2;

  // animation state
  logic [31:0] start_time;
  logic [31:0] origin_value;
  logic [31:0] target_value;
  logic        running;

  // sequencer and datapath registers
  eca_pkg::state_t st, st_next;
  logic [3:0]         ph;
  logic [CW-1:0]      cnt;
  logic               fin;
  logic [15:0]        x;
  logic signed [23:0] yv;
  logic [31:0]        r;
  logic [32:0]        lo, hi;
  logic [31:0]        t;
  logic [32:0]        ub;
  logic [31:0]        ut, tt, b1, b2, b3;
  logic signed [55:0] acc;
  logic [31:0]        res_val;
  logic               res_act;
  logic               ov;
  logic [31:0]        ov_val;
  logic               ov_act;

  // combinational signals and divider and multiplier outputs
  logic               accept;
  logic [31:0]        el;
  logic               need_div;
  logic               div_start;
  logic               div_done;
  logic [15:0]        div_q;
  logic               shape_done;
  logic               load;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;
  logic [16:0]        u;
  logic [19:0]        e;
  logic [31:0]        r_sh;
  logic signed [23:0] quad_y, cubic_y, exp_y;
  logic [33:0]        gsum;
  logic signed [55:0] pp;
  logic signed [MW-1:0] p1sel, p2sel;
  logic signed [32:0] diff;
  logic signed [52:0] vsum;
  logic [31:0]        sat_val;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      animate_enable <= 1'b0;
      curve_mode     <= eca_pkg::MODE_LINEAR;
      anim_len       <= eca_pkg::DURATION_RST;
      ctrl_x1        <= eca_pkg::CTRL_X1_RST;
      ctrl_y1        <= eca_pkg::CTRL_Y1_RST;
      ctrl_x2        <= eca_pkg::CTRL_X2_RST;
      ctrl_y2        <= eca_pkg::CTRL_Y2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        eca_pkg::REG_ANIMATE_ENABLE: animate_enable <= cfg_data[0];
        eca_pkg::REG_CURVE_MODE:     curve_mode     <= cfg_data[2:0];
        eca_pkg::REG_ANIM_LEN:       anim_len       <= cfg_data[15:0];
        eca_pkg::REG_CTRL_X1:        ctrl_x1        <= cfg_data[16:0];
        eca_pkg::REG_CTRL_Y1:        ctrl_y1        <= $signed(cfg_data[17:0]);
        eca_pkg::REG_CTRL_X2:        ctrl_x2        <= cfg_data[16:0];
        eca_pkg::REG_CTRL_Y2:        ctrl_y2        <= $signed(cfg_data[17:0]);
        default: ;
      endcase
    end
  end

  // item decode
  assign accept   = in_ch.valid && (st == eca_pkg::S_IDLE);
  assign el       = in_ch.now_ms - start_time;
  assign need_div = (in_ch.action == eca_pkg::ACT_SAMPLE) && running && (el != 32'd0) &&
                    !el[31] && (el < {16'd0, anim_len});
  assign load     = (st == eca_pkg::S_DONE) && (!ov || out_ch.ready);

  // curve helpers
  assign u       = 17'h10000 - {1'b0, x};
  assign e       = {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
  assign r_sh    = r >> e[19:16];
  assign quad_y  = $signed(24'h010000 - {7'd0, mul_p[32:16]});
  assign cubic_y = $signed(24'h010000 - {7'd0, mul_p[48:32]});
  assign exp_y   = $signed(24'h010000 - {7'd0, r_sh[31:15]});
  assign gsum    = {1'b0, lo} + {1'b0, hi};
  assign pp      = $signed(mul_p[55:0]);
  assign p1sel   = fin ? MW'(ctrl_y1) : $signed({{(MW-17){1'b0}}, ctrl_x1});
  assign p2sel   = fin ? MW'(ctrl_y2) : $signed({{(MW-17){1'b0}}, ctrl_x2});
  assign diff    = $signed({target_value[31], target_value}) -
                   $signed({origin_value[31], origin_value});

  // interpolation and saturation
  assign vsum = 53'($signed(mul_p[67:16])) + 53'($signed(origin_value));
  always_comb begin
    if (vsum > eca_pkg::SAT_MAX) begin
      sat_val = eca_pkg::SAT_MAX[31:0];
    end else if (vsum < eca_pkg::SAT_MIN) begin
      sat_val = eca_pkg::SAT_MIN[31:0];
    end else begin
      sat_val = vsum[31:0];
    end
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      eca_pkg::S_IDLE:  if (accept) st_next = need_div ? eca_pkg::S_DIV : eca_pkg::S_DONE;
      eca_pkg::S_DIV:   if (div_done) st_next = eca_pkg::S_SHAPE;
      eca_pkg::S_SHAPE: if (shape_done) st_next = eca_pkg::S_LERP;
      eca_pkg::S_LERP:  if (ph == 4'd1) st_next = eca_pkg::S_DONE;
      eca_pkg::S_DONE:  if (load) st_next = eca_pkg::S_IDLE;
      default:          st_next = eca_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider start, multiplier operands
  always_comb begin
    in_ch.ready = (st == eca_pkg::S_IDLE);
    div_start   = accept && need_div;
    shape_done  = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    case (st)
      eca_pkg::S_SHAPE: begin
        case (curve_mode)
          eca_pkg::MODE_LINEAR: shape_done = 1'b1;
          eca_pkg::MODE_QUAD: begin
            shape_done = (ph == 4'd1);
            mul_a      = MW'(u);
            mul_b      = MW'(u);
          end
          eca_pkg::MODE_CUBIC: begin
            shape_done = (ph == 4'd2);
            mul_a      = (ph == 4'd0) ? MW'(u) : $signed(mul_p[MW-1:0]);
            mul_b      = MW'(u);
          end
          eca_pkg::MODE_EXP: begin
            shape_done = (ph == 4'd3);
            mul_a      = MW'(r);
            mul_b      = MW'(eca_pkg::EXP_C[cnt[3:0]]);
          end
          default: begin
            shape_done = ((ph == 4'd0) && (x == 16'd0)) || ((ph == 4'd9) && fin);
            case (ph)
              4'd1: begin mul_a = MW'(ub); mul_b = MW'(t); end
              4'd2: begin mul_a = MW'(t);  mul_b = MW'(t); end
              4'd3: begin mul_a = MW'(ut); mul_b = MW'(ub); end
              4'd4: begin mul_a = MW'(ut); mul_b = MW'(t); end
              4'd5: begin mul_a = MW'(tt); mul_b = MW'(t); end
              4'd6: begin mul_a = MW'(b1); mul_b = p1sel; end
              4'd7: begin mul_a = MW'(b2); mul_b = p2sel; end
              default: ;
            endcase
          end
        endcase
      end
      eca_pkg::S_LERP: begin
        mul_a = MW'(yv);
        mul_b = MW'(diff);
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= eca_pkg::S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // animation state and item results
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time   <= '0;
      origin_value <= '0;
      target_value <= '0;
      running      <= 1'b0;
    end else if (accept) begin
      if (in_ch.action == eca_pkg::ACT_START) begin
        start_time   <= in_ch.now_ms;
        origin_value <= in_ch.from_value;
        target_value <= in_ch.to_value;
        running      <= animate_enable;
      end else if (running && (el != 32'd0) && !el[31] && !need_div) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_act <= need_div;
      if (in_ch.action == eca_pkg::ACT_START) begin
        res_val <= animate_enable ? in_ch.from_value : in_ch.to_value;
        res_act <= animate_enable;
      end else if (!running) begin
        res_val <= target_value;
      end else if ((el == 32'd0) || el[31]) begin
        res_val <= origin_value;
        res_act <= 1'b1;
      end else if (!need_div) begin
        res_val <= target_value;
      end
    end else if ((st == eca_pkg::S_LERP) && (ph == 4'd1)) begin
      res_val <= sat_val;
    end
  end

  // curve datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      ph  <= '0;
      cnt <= '0;
      fin <= 1'b0;
    end else begin
      case (st)
        eca_pkg::S_DIV: begin
          if (div_done) begin
            x   <= div_q;
            ph  <= '0;
            cnt <= '0;
            fin <= 1'b0;
            lo  <= '0;
            hi  <= 33'h1_0000_0000;
          end
        end
        eca_pkg::S_SHAPE: begin
          case (curve_mode)
            eca_pkg::MODE_LINEAR: yv <= $signed({8'd0, x});
            eca_pkg::MODE_QUAD: begin
              if (ph == 4'd0) begin
                ph <= 4'd1;
              end else begin
                yv <= quad_y;
                ph <= '0;
              end
            end
            eca_pkg::MODE_CUBIC: begin
              if (ph == 4'd2) begin
                yv <= cubic_y;
                ph <= '0;
              end else begin
                ph <= ph + 4'd1;
              end
            end
            eca_pkg::MODE_EXP: begin
              case (ph)
                4'd0: begin
                  r   <= 32'h8000_0000;
                  cnt <= '0;
                  ph  <= 4'd1;
                end
                4'd1: ph <= 4'd2;
                4'd2: begin
                  // multiply in the root only where the fraction bit is set
                  if (e[~cnt[3:0]]) r <= mul_p[62:31];
                  cnt <= cnt + CW'(1);
                  ph  <= (cnt[3:0] == 4'd15) ? 4'd3 : 4'd1;
                end
                default: begin
                  yv <= exp_y;
                  ph <= '0;
                end
              endcase
            end
            default: begin
              // bezier: one bisection step per pass through phases 0 to 9
              case (ph)
                4'd0: begin
                  if (x == 16'd0) begin
                    yv <= '0;
                  end else begin
                    t  <= gsum[32:1];
                    ub <= 33'h1_0000_0000 - {1'b0, gsum[32:1]};
                    ph <= 4'd1;
                  end
                end
                4'd2: begin ut <= mul_p[63:32]; ph <= 4'd3; end
                4'd3: begin tt <= mul_p[63:32]; ph <= 4'd4; end
                4'd4: begin b1 <= mul_p[63:32]; ph <= 4'd5; end
                4'd5: begin b2 <= mul_p[63:32]; ph <= 4'd6; end
                4'd6: begin b3 <= mul_p[63:32]; ph <= 4'd7; end
                4'd7: begin acc <= pp + (pp <<< 1); ph <= 4'd8; end
                4'd8: begin
                  acc <= acc + pp + (pp <<< 1) + $signed({8'd0, b3, 16'd0});
                  ph  <= 4'd9;
                end
                4'd9: begin
                  ph <= '0;
                  if (fin) begin
                    yv <= acc[55:32];
                  end else begin
                    if ($signed({8'd0, x, 32'd0}) < acc) begin
                      hi <= {1'b0, t};
                    end else begin
                      lo <= {1'b0, t};
                    end
                    if (cnt == CW'(BISECT_STEPS - 1)) fin <= 1'b1;
                    cnt <= cnt + CW'(1);
                  end
                end
                default: ph <= ph + 4'd1;
              endcase
            end
          endcase
        end
        eca_pkg::S_LERP: ph <= (ph == 4'd0) ? 4'd1 : 4'd0;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ov_val <= res_val;
      ov_act <= res_act;
    end
  end

  assign out_ch.valid         = ov;
  assign out_ch.current_value = ov_val;
  assign out_ch.still_active  = ov_act;

  // fraction divider
  eca_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (el[15:0]),
    .den   (anim_len),
    .q     (div_q),
    .done  (div_done)
  );

  // shared multiplier
  eca_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // a result enters the output register only from the result state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(st == eca_pkg::S_DONE))
    else $error("result register loaded outside the result state");

  // a start item leaves the active flag equal to the enable register
  a_start_running: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_ch.action == eca_pkg::ACT_START)) |=> (running == $past(animate_enable)))
    else $error("start item did not set the active flag from the enable");

  // the divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (st == eca_pkg::S_DIV))
    else $error("divider finished outside the division state");

endmodule

// ===== hdl/eca_div.sv =====
// radix-2 restoring divider giving the q0.16 fraction num/den, num < den
module eca_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic [15:0] q,
  output logic        done
);

  logic [16:0] rem;
  logic [15:0] den_q;
  logic [3:0]  n;
  logic        busy;
  logic [16:0] r2;
  logic        fits;

  // shifted remainder and trial compare
  assign r2   = {rem[15:0], 1'b0};
  assign fits = r2 >= {1'b0, den_q};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      n    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n    <= '0;
      end else if (busy) begin
        n <= n + 4'd1;
        if (n == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_q <= den;
      q     <= '0;
    end else if (busy) begin
      rem <= fits ? (r2 - {1'b0, den_q}) : r2;
      q   <= {q[14:0], fits};
    end
  end

endmodule

// ===== hdl/eca_mul.sv =====
// shared signed multiplier with registered product
module eca_mul (
  input  logic                                clk,
  input  logic signed [eca_pkg::MUL_W-1:0]    a,
  input  logic signed [eca_pkg::MUL_W-1:0]    b,
  output logic signed [2*eca_pkg::MUL_W-1:0]  p
);

  // product register
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the easing curve animator top level
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CIW = eca_pkg::CFG_IDX_W;
  localparam int unsigned CDW = eca_pkg::CFG_DATA_W;
  localparam logic [CIW-1:0] REG_UNUSED = 3'd7;
  localparam int CLK_HALF = 10;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned BISECT = eca_pkg::BISECT_STEPS_DEF;
  localparam int RAND_PHASES = 30;
  localparam int ITEMS_PER_PHASE = 50;

  typedef struct packed {
    logic signed [31:0] value;
    logic               active;
  } anim_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CIW-1:0]        idx;
    logic [CDW-1:0]        data;
    logic                  action;
    logic [31:0]           now;
    logic signed [31:0]    from_v;
    logic signed [31:0]    to_v;
    bit                    typed;
    logic signed [31:0]    exp_value;
    logic                  exp_active;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CIW-1:0] cfg_index = '0;
  logic [CDW-1:0] cfg_data = '0;

  eca_in_if  in_ch ();
  eca_out_if out_ch ();

  easing_curve_animator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // shadow registers and animation state
  logic               m_enable;
  logic [2:0]         m_mode;
  logic [15:0]        m_duration;
  logic [16:0]        m_x1, m_x2;
  logic signed [17:0] m_y1, m_y2;
  logic [31:0]        m_start;
  logic signed [31:0] m_origin, m_target;
  logic               m_running;
  longint unsigned    exp_roots [16];

  anim_result_t expected_results [$];
  bit           pin_result;
  anim_result_t pinned_result;
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  items_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  curve_samples = 0;
  int unsigned  burst_left = 0;
  bit           no_gaps = 1'b0;

  // floor integer square root
  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned rem, root, b;
    rem = n;
    root = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // 1 - 2^(-10x) in q.16
  function automatic longint exp_curve(longint unsigned x);
    longint unsigned e, r;
    e = 10 * x;
    r = 64'h8000_0000;
    for (int j = 1; j <= 16; j++) begin
      if (e[16-j]) r = (r * exp_roots[j-1]) >> 31;
    end
    r = (e >> 16) >= 32 ? 0 : r >> (e >> 16);
    return 65536 - longint'(r >> 15);
  endfunction

  // bezier component at q0.32 parameter, q.48 result
  function automatic longint bez_point(longint p1, longint p2, longint unsigned t);
    longint unsigned u, ut, b1, b2, b3;
    u = (64'd1 << 32) - t;
    ut = (u * t) >> 32;
    b1 = (ut * u) >> 32;
    b2 = (ut * t) >> 32;
    b3 = (((t * t) >> 32) * t) >> 32;
    return 3 * longint'(b1) * p1 + 3 * longint'(b2) * p2 + longint'(b3) * 65536;
  endfunction

  // bisection on x(t), then y at the final midpoint
  function automatic longint bezier_curve(longint unsigned x);
    longint unsigned lo, hi, mid;
    longint xs;
    lo = 0;
    hi = 64'd1 << 32;
    xs = longint'(x << 32);
    if (x == 0) return 0;
    for (int i = 0; i < BISECT; i++) begin
      mid = (lo + hi) >> 1;
      if (xs < bez_point(longint'(m_x1), longint'(m_x2), mid)) hi = mid;
      else lo = mid;
    end
    return bez_point(longint'(m_y1), longint'(m_y2), (lo + hi) >> 1) >>> 32;
  endfunction

  function automatic longint shape_fraction(longint unsigned x);
    longint unsigned u;
    u = 65536 - x;
    case (m_mode)
      eca_pkg::MODE_LINEAR: return longint'(x);
      eca_pkg::MODE_QUAD:   return 65536 - longint'((u * u) >> 16);
      eca_pkg::MODE_CUBIC:  return 65536 - longint'((u * u * u) >> 32);
      eca_pkg::MODE_EXP:    return exp_curve(x);
      default:              return bezier_curve(x);
    endcase
  endfunction

  // next value of the animation for one accepted item
  function automatic anim_result_t animate_step(logic action, logic [31:0] now,
                                                logic signed [31:0] from_v,
                                                logic signed [31:0] to_v);
    anim_result_t res;
    logic [31:0] elapsed;
    longint unsigned frac;
    longint v, diff;
    elapsed = now - m_start;
    if (action == eca_pkg::ACT_START) begin
      m_start = now;
      m_origin = from_v;
      m_target = to_v;
      m_running = m_enable;
      res.value = m_running ? m_origin : m_target;
    end else if (!m_running) begin
      res.value = m_target;
    end else if (elapsed == 0 || elapsed[31]) begin
      res.value = m_origin;
    end else if (elapsed >= m_duration) begin
      m_running = 1'b0;
      res.value = m_target;
    end else begin
      curve_samples++;
      frac = (longint'(elapsed) << 16) / m_duration;
      diff = longint'(m_target) - longint'(m_origin);
      v = ((shape_fraction(frac) * diff) >>> 16) + longint'(m_origin);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      res.value = v[31:0];
    end
    res.active = m_running;
    return res;
  endfunction

  // accepted input items feed the predictor
  always @(posedge clk) begin
    anim_result_t res;
    if (!rst && in_ch.valid && in_ch.ready) begin
      res = animate_step(in_ch.action, in_ch.now_ms, in_ch.from_value, in_ch.to_value);
      if (pin_result) res = pinned_result;
      expected_results.push_back(res);
    end
  end

  // result checker
  always @(posedge clk) begin
    anim_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected item value=%0d active=%0b", $time,
                 out_ch.current_value, out_ch.still_active);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.current_value !== exp_r.value) begin
          errors++;
          $display("%0t: current_value expected %0d actual %0d", $time,
                   exp_r.value, out_ch.current_value);
        end
        if (out_ch.still_active !== exp_r.active) begin
          errors++;
          $display("%0t: still_active expected %0b actual %0b", $time,
                   exp_r.active, out_ch.still_active);
        end
      end
    end
  end

  // receiver stall pattern, cycling through always ready, random ready and random stall bursts
  always @(negedge clk) begin
    int unsigned stall_left;
    if (rst) begin
      out_ch.ready = 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else begin
      case ((cycles >> 8) % 3)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        default: begin
          out_ch.ready = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 40);
        end
      endcase
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("easing_curve_animator_top test failed");
      $finish;
    end
  end

  // one item, sent in bursts with random gaps unless no_gaps is set; called at a falling edge
  task automatic send_item(logic action, logic [31:0] now, logic signed [31:0] from_v,
                           logic signed [31:0] to_v, bit typed, anim_result_t typed_res);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!no_gaps) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(0, 25)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.action = action;
    in_ch.now_ms = now;
    in_ch.from_value = from_v;
    in_ch.to_value = to_v;
    pin_result = typed;
    pinned_result = typed_res;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // hold off until every result is in and the block has settled
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    pin_result = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write, mirrored into the shadow copy
  task automatic write_reg(logic [CIW-1:0] idx, logic [CDW-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      eca_pkg::REG_ANIMATE_ENABLE: m_enable = data[0];
      eca_pkg::REG_CURVE_MODE:     m_mode = data[2:0];
      eca_pkg::REG_ANIM_LEN:       m_duration = data[15:0];
      eca_pkg::REG_CTRL_X1:        m_x1 = data[16:0];
      eca_pkg::REG_CTRL_Y1:        m_y1 = data[17:0];
      eca_pkg::REG_CTRL_X2:        m_x2 = data[16:0];
      eca_pkg::REG_CTRL_Y2:        m_y2 = data[17:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic stim_row_t item_row(logic action, logic [31:0] now,
                                         logic signed [31:0] from_v,
                                         logic signed [31:0] to_v);
    stim_row_t r;
    r = '{ROW_ITEM, '0, '0, action, now, from_v, to_v, 1'b0, '0, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic action, logic [31:0] now,
                                          logic signed [31:0] from_v,
                                          logic signed [31:0] to_v,
                                          logic signed [31:0] ev, logic ea);
    stim_row_t r;
    r = '{ROW_ITEM, '0, '0, action, now, from_v, to_v, 1'b1, ev, ea};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CIW-1:0] idx,
                                        logic [CDW-1:0] data);
    stim_row_t r;
    r = '{ROW_CFG, idx, data, eca_pkg::ACT_START, '0, '0, '0, 1'b0, '0, 1'b0};
    return r;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1: return $signed(32'($urandom_range(0, 200000))) - 32'sd100000;
      default: return $urandom;
    endcase
  endfunction

  // random register settings for one phase, extremes in the first two
  task automatic set_phase_regs(int phase);
    logic [15:0] dur;
    case ($urandom_range(0, 9))
      0: dur = 16'd0;
      1: dur = 16'hffff;
      2: dur = 16'd1;
      default: dur = 16'($urandom_range(2, 400));
    endcase
    if (phase == 0) begin
      write_reg(eca_pkg::REG_ANIMATE_ENABLE, CDW'(1));
      write_reg(eca_pkg::REG_CURVE_MODE, CDW'(7));
      write_reg(eca_pkg::REG_ANIM_LEN, CDW'(16'hffff));
      write_reg(eca_pkg::REG_CTRL_X1, CDW'(17'h1ffff));
      write_reg(eca_pkg::REG_CTRL_Y1, 18'h1ffff);
      write_reg(eca_pkg::REG_CTRL_X2, CDW'(17'h1ffff));
      write_reg(eca_pkg::REG_CTRL_Y2, 18'h1ffff);
    end else if (phase == 1) begin
      write_reg(eca_pkg::REG_CURVE_MODE, CDW'(eca_pkg::MODE_BEZIER));
      write_reg(eca_pkg::REG_ANIM_LEN, CDW'(16'd3));
      write_reg(eca_pkg::REG_CTRL_X1, '0);
      write_reg(eca_pkg::REG_CTRL_Y1, 18'h20000);
      write_reg(eca_pkg::REG_CTRL_X2, '0);
      write_reg(eca_pkg::REG_CTRL_Y2, 18'h20000);
    end else begin
      write_reg(eca_pkg::REG_ANIMATE_ENABLE, CDW'($urandom_range(0, 9) != 0));
      write_reg(eca_pkg::REG_CURVE_MODE, CDW'($urandom_range(0, 7)));
      write_reg(eca_pkg::REG_ANIM_LEN, CDW'(dur));
      write_reg(eca_pkg::REG_CTRL_X1,
                CDW'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536)));
      write_reg(eca_pkg::REG_CTRL_Y1, CDW'($urandom));
      write_reg(eca_pkg::REG_CTRL_X2,
                CDW'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536)));
      write_reg(eca_pkg::REG_CTRL_Y2, CDW'($urandom));
      if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, CDW'($urandom));
    end
  endtask

  initial begin
    stim_row_t    rows [$];
    anim_result_t none;
    anim_result_t typed_res;
    logic [31:0]  t0, span;
    int           phase_items;

    none = '0;
    in_ch.valid = 1'b0;
    in_ch.action = eca_pkg::ACT_START;
    in_ch.now_ms = '0;
    in_ch.from_value = '0;
    in_ch.to_value = '0;
    pin_result = 1'b0;
    pinned_result = '0;

    // reset values of the shadow copy
    m_enable = 1'b0;
    m_mode = eca_pkg::MODE_LINEAR;
    m_duration = eca_pkg::DURATION_RST;
    m_x1 = eca_pkg::CTRL_X1_RST;
    m_y1 = eca_pkg::CTRL_Y1_RST;
    m_x2 = eca_pkg::CTRL_X2_RST;
    m_y2 = eca_pkg::CTRL_Y2_RST;
    m_start = '0;
    m_origin = '0;
    m_target = '0;
    m_running = 1'b0;

    // q1.31 roots of one half
    exp_roots[0] = sqrt_floor(64'd1 << 61);
    for (int j = 1; j < 16; j++) exp_roots[j] = sqrt_floor(exp_roots[j-1] << 31);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows
    rows.push_back(typed_row(eca_pkg::ACT_SAMPLE, 5, 7, 9, 0, 1'b0));
    rows.push_back(typed_row(eca_pkg::ACT_START, 10, 100, 32'sh7fff_ffff,
                             32'sh7fff_ffff, 1'b0));
    rows.push_back(cfg_row(eca_pkg::REG_ANIMATE_ENABLE, 18'd1));
    rows.push_back(typed_row(eca_pkg::ACT_START, 1000, 32'sh8000_0000, 32'sh7fff_ffff,
                             32'sh8000_0000, 1'b1));
    rows.push_back(typed_row(eca_pkg::ACT_SAMPLE, 1000, 0, 0, 32'sh8000_0000, 1'b1));
    rows.push_back(item_row(eca_pkg::ACT_SAMPLE, 1125, 0, 0));
    rows.push_back(typed_row(eca_pkg::ACT_SAMPLE, 999, 0, 0, 32'sh8000_0000, 1'b1));
    rows.push_back(typed_row(eca_pkg::ACT_SAMPLE, 1250, 0, 0, 32'sh7fff_ffff, 1'b0));
    rows.push_back(typed_row(eca_pkg::ACT_SAMPLE, 1300, 0, 0, 32'sh7fff_ffff, 1'b0));
    rows.push_back(cfg_row(eca_pkg::REG_CURVE_MODE, CDW'(eca_pkg::MODE_QUAD)));
    rows.push_back(typed_row(eca_pkg::ACT_START, 32'hffff_ff00, 0, 32'sh1_0000, 0, 1'b1));
    rows.push_back(item_row(eca_pkg::ACT_SAMPLE, 32'hffff_ff80, 0, 0));
    rows.push_back(typed_row(eca_pkg::ACT_SAMPLE, 32'h10, 0, 0, 32'sh1_0000, 1'b0));
    rows.push_back(cfg_row(eca_pkg::REG_CURVE_MODE, CDW'(eca_pkg::MODE_CUBIC)));
    rows.push_back(item_row(eca_pkg::ACT_START, 0, 32'sh7fff_ffff, 32'sh8000_0000));
    rows.push_back(item_row(eca_pkg::ACT_SAMPLE, 100, 0, 0));
    rows.push_back(cfg_row(eca_pkg::REG_CURVE_MODE, CDW'(eca_pkg::MODE_EXP)));
    rows.push_back(item_row(eca_pkg::ACT_SAMPLE, 249, 0, 0));
    rows.push_back(cfg_row(eca_pkg::REG_CURVE_MODE, CDW'(eca_pkg::MODE_BEZIER)));
    rows.push_back(item_row(eca_pkg::ACT_SAMPLE, 1, 0, 0));
    rows.push_back(item_row(eca_pkg::ACT_SAMPLE, 125, 0, 0));
    rows.push_back(cfg_row(eca_pkg::REG_CURVE_MODE, 18'd7));
    rows.push_back(item_row(eca_pkg::ACT_SAMPLE, 200, 0, 0));
    rows.push_back(cfg_row(eca_pkg::REG_ANIM_LEN, 18'd0));
    rows.push_back(cfg_row(REG_UNUSED, 18'h3ffff));
    rows.push_back(typed_row(eca_pkg::ACT_START, 50, 5, 9, 5, 1'b1));
    rows.push_back(typed_row(eca_pkg::ACT_SAMPLE, 51, 0, 0, 9, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        typed_res.value = rows[i].exp_value;
        typed_res.active = rows[i].exp_active;
        send_item(rows[i].action, rows[i].now, rows[i].from_v, rows[i].to_v,
                  rows[i].typed, typed_res);
      end
    end
    pin_result = 1'b0;

    // random phases: start then samples across the duration, with some noise
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      set_phase_regs(phase);
      no_gaps = (phase % 4) == 3;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        t0 = $urandom;
        send_item(eca_pkg::ACT_START, t0, rand_value(), rand_value(), 1'b0, none);
        phase_items++;
        span = m_duration + m_duration / 4 + 2;
        repeat ($urandom_range(2, 12)) begin
          case ($urandom_range(0, 9))
            0: send_item(eca_pkg::ACT_SAMPLE, $urandom, $urandom, $urandom, 1'b0, none);
            1: send_item(eca_pkg::ACT_SAMPLE, t0 - $urandom_range(0, 3), $urandom, $urandom,
                         1'b0, none);
            default: send_item(eca_pkg::ACT_SAMPLE, t0 + $urandom_range(0, span), $urandom,
                               $urandom, 1'b0, none);
          endcase
          phase_items++;
        end
      end
    end

    wait_idle();
    $display("run: %0d items, %0d results, %0d curve samples over %0d register settings",
             items_sent, results_seen, curve_samples, RAND_PHASES + 6);
    if (errors == 0) begin
      $display("easing_curve_animator_top test passed");
    end else begin
      $display("easing_curve_animator_top test failed");
    end
    $finish;
  end

endmodule

// ===== easing_curve_animator_top.f =====
hdl/eca_pkg.sv
hdl/eca_if.sv
hdl/eca_div.sv
hdl/eca_mul.sv
hdl/easing_curve_animator_top.sv
tb/testbench.sv
